// File: design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg - shared definitions for the sorted priority queue
// Sizes, operation codes and the structs that run along the cell chain.
// ---------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY  = 16;
	localparam int RANK_BITS = 8;

	localparam int VALUE_W = 32;
	localparam int ITEM_RANK_W = 8;
	localparam int OCC_W = 5;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_SEARCH  = 2'd2;

	typedef logic [RANK_BITS-1:0] rank_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// broadcast to every cell
	typedef struct packed {
		logic   enq;
		value_t value;
		rank_t  rank;
	} spq_cmd_t;

	// handed from a cell to its right-hand neighbor
	typedef struct packed {
		logic   keep;
		value_t value;
		rank_t  rank;
	} spq_link_t;

	function automatic rank_t to_rank(input logic [ITEM_RANK_W-1:0] r);
		logic [15+ITEM_RANK_W:0] w;
		begin
			w = {16'h0, r};
			return w[RANK_BITS-1:0];
		end
	endfunction

	function automatic logic [ITEM_RANK_W-1:0] from_rank(input rank_t r);
		logic [ITEM_RANK_W+RANK_BITS-1:0] w;
		begin
			w = {{ITEM_RANK_W{1'b0}}, r};
			return w[ITEM_RANK_W-1:0];
		end
	endfunction

endpackage

// File: design/spq_if.sv
// ---------------------------------------------------------------------------
// spq_req_if / spq_rsp_if - request and response channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface spq_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [31:0] item_value;
	logic [7:0]        item_rank;

	modport source (output valid, op, item_value, item_rank, input ready);
	modport sink   (input valid, op, item_value, item_rank, output ready);
endinterface

interface spq_rsp_if;
	logic              valid;
	logic              ready;
	logic              ok;
	logic signed [31:0] removed_value;
	logic [7:0]        removed_rank;
	logic [4:0]        occupancy;

	modport source (output valid, ok, removed_value, removed_rank, occupancy, input ready);
	modport sink   (input valid, ok, removed_value, removed_rank, occupancy, output ready);
endinterface

// File: design/sorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_core - sorted-list priority queue on a cell chain
//
// Requests arrive on req (op, item_value, item_rank) and each one yields
// exactly one response on rsp (ok, removed_value, removed_rank, occupancy).
//   enqueue : insert ahead of every entry of equal or lower rank; ok=0 if full
//   dequeue : remove the oldest entry of the lowest rank; ok=0 if empty
//   search  : ok=1 if any stored entry holds item_value
// The response is registered: a request accepted at one edge has its response in
// the output register after that edge. One request per cycle is sustained while
// rsp.ready stays high; every cell compares against the broadcast request and
// shifts right in the same cycle, so throughput is set by the single chain pass.
// A stalled receiver holds the response register; req.ready drops only
// while a response is held and rsp.ready is low.
// Reset clears the entry count and the response valid; slot contents are
// not cleared, since slots at or above the count are never read.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core (
	input  logic         clk,
	input  logic         arst_n,
	spq_req_if.sink      req,
	spq_rsp_if.source    rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_vld_q;
	logic             ok_q;
	value_t           rem_value_q;
	logic [7:0]       rem_rank_q;
	logic [CNT_W-1:0] occ_q;

	logic             accept;
	logic             full, empty;
	logic             is_enq, is_deq, is_srch;
	spq_cmd_t         cmd;
	spq_link_t        link [CAPACITY+1];
	logic [CAPACITY-1:0] match;
	logic [IDX_W-1:0] tail_idx;
	value_t           cell_value [CAPACITY];
	rank_t            cell_rank  [CAPACITY];
	logic [CNT_W-1:0] count_d;
	logic [CNT_W+OCC_W-1:0] occ_wide;

	// output register frees the input side whenever it drains
	assign req.ready = !rsp_vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign is_enq  = (req.op == OP_ENQUEUE);
	assign is_deq  = (req.op == OP_DEQUEUE);
	assign is_srch = (req.op == OP_SEARCH);

	assign cmd.enq   = accept && is_enq && !full;
	assign cmd.value = req.item_value;
	assign cmd.rank  = to_rank(req.item_rank);

	// head of the chain: its left link reads as keeping, so the head takes the
	// new entry unless it outranks it
	assign link[0].keep  = 1'b1;
	assign link[0].value = '0;
	assign link[0].rank  = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (CNT_W'(i) < count_q),
			.left     (link[i]),
			.right    (link[i+1]),
			.match    (match[i])
		);
		assign cell_value[i] = link[i+1].value;
		assign cell_rank[i]  = link[i+1].rank;
	end

	// low end of the list sits at slot count-1
	assign tail_idx = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		count_d = count_q;
		if (cmd.enq)
			count_d = count_q + CNT_W'(1);
		else if (accept && is_deq && !empty)
			count_d = count_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept)
				rsp_vld_q <= 1'b1;
			else if (rsp.ready)
				rsp_vld_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q        <= 1'b0;
			rem_value_q <= '0;
			rem_rank_q  <= '0;
			occ_q       <= count_d;
			case (req.op)
				OP_ENQUEUE: ok_q <= !full;
				OP_DEQUEUE: begin
					if (!empty) begin
						ok_q        <= 1'b1;
						rem_value_q <= cell_value[tail_idx];
						rem_rank_q  <= from_rank(cell_rank[tail_idx]);
					end
				end
				OP_SEARCH: ok_q <= |match;
				default:   ok_q <= 1'b0;
			endcase
		end
	end

	assign occ_wide = {{OCC_W{1'b0}}, occ_q};

	assign rsp.valid         = rsp_vld_q;
	assign rsp.ok            = ok_q;
	assign rsp.removed_value = rem_value_q;
	assign rsp.removed_rank  = rem_rank_q;
	assign rsp.occupancy     = occ_wide[OCC_W-1:0];

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_enq && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("enqueue did not grow the list");

	a_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_deq && empty) |=> (!ok_q && rem_value_q == '0 && count_q == '0))
		else $error("dequeue on empty list misreported");

	a_srch_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_srch) |=> (count_q == $past(count_q) && rsp_vld_q))
		else $error("search changed the list or lost its response");

endmodule

// File: design/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell - one slot of the sorted chain
// Keeps its entry, takes the new entry, or takes its left neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell (
	input  logic              clk,
	input  spq_pkg::spq_cmd_t  cmd,
	input  logic              occupied,
	input  spq_pkg::spq_link_t left,
	output spq_pkg::spq_link_t right,
	output logic              match
);
	import spq_pkg::*;

	value_t value_q;
	rank_t  rank_q;
	logic   keep;

	// entries are sorted, so the "keeps" run is a prefix of the chain
	assign keep  = occupied && (rank_q > cmd.rank);
	assign match = occupied && (value_q == cmd.value);

	assign right.keep  = keep;
	assign right.value = value_q;
	assign right.rank  = rank_q;

	always_ff @(posedge clk) begin
		if (cmd.enq && !keep) begin
			if (left.keep) begin
				value_q <= cmd.value;
				rank_q  <= cmd.rank;
			end else begin
				value_q <= left.value;
				rank_q  <= left.rank;
			end
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - testbench for sorted_priority_queue_core
// Drives enqueue, dequeue and search requests through the request channel
// and predicts every response with a software copy of the sorted store.
// Responses are checked field by field and in order. Both channels idle and
// stall in random bursts, and the store is run full and empty many times.
// ---------------------------------------------------------------------------
module tb_top;
	import spq_pkg::*;

	// op code 3 has no meaning; the block must answer it with ok low
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 400000;

	typedef struct {
		logic                   ok;
		value_t                 removed_value;
		logic [ITEM_RANK_W-1:0] removed_rank;
		logic [OCC_W-1:0]       occupancy;
	} queue_response_t;

	// Holds a copy of the ranked store and the responses still owed by the block.
	class ranked_store_tracker;
		value_t          slot_value [CAPACITY];
		rank_t           slot_rank [CAPACITY];
		int              held;
		int              errors;
		queue_response_t awaited [$];

		function new();
			held = 0;
			errors = 0;
		endfunction

		// works out the response to one accepted request and updates the store
		function void note_request(input logic [1:0] op, input value_t value,
			input logic [ITEM_RANK_W-1:0] item_rank);
			queue_response_t resp;
			rank_t           rank;
			int              pos;
			rank = rank_t'(item_rank);
			resp.ok = 1'b0;
			resp.removed_value = '0;
			resp.removed_rank = '0;
			case (op)
				OP_ENQUEUE: begin
					if (held < CAPACITY) begin
						// new entry goes ahead of every entry of equal or lower rank
						pos = 0;
						while (pos < held && slot_rank[pos] > rank)
							pos++;
						for (int k = held; k > pos; k--) begin
							slot_value[k] = slot_value[k-1];
							slot_rank[k] = slot_rank[k-1];
						end
						slot_value[pos] = value;
						slot_rank[pos] = rank;
						held++;
						resp.ok = 1'b1;
					end
				end
				OP_DEQUEUE: begin
					if (held > 0) begin
						held--;
						resp.removed_value = slot_value[held];
						resp.removed_rank = ITEM_RANK_W'(slot_rank[held]);
						resp.ok = 1'b1;
					end
				end
				OP_SEARCH: begin
					for (int k = 0; k < held; k++)
						if (slot_value[k] == value)
							resp.ok = 1'b1;
				end
				default: begin
				end
			endcase
			resp.occupancy = OCC_W'(held);
			awaited.push_back(resp);
		endfunction

		function void check_response(input queue_response_t got);
			queue_response_t want;
			if (awaited.size() == 0) begin
				$display("%0t: response with none outstanding: ok %b value %h rank %h occ %0d",
					$time, got.ok, got.removed_value, got.removed_rank, got.occupancy);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.ok !== want.ok) begin
				$display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
				errors++;
			end
			if (got.removed_value !== want.removed_value) begin
				$display("%0t: removed_value expected %h actual %h", $time,
					want.removed_value, got.removed_value);
				errors++;
			end
			if (got.removed_rank !== want.removed_rank) begin
				$display("%0t: removed_rank expected %h actual %h", $time,
					want.removed_rank, got.removed_rank);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$display("%0t: occupancy expected %0d actual %0d", $time,
					want.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ranked_store_tracker tracker = new();

	// idling controls; steady turns all idling off for the closing stretch
	bit steady;
	int sender_gap_pct;
	int sink_stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: the slowest legal run is far below this.
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("Run limit of %0d cycles reached, %0d requests outstanding",
			RUN_LIMIT, tracker.awaited.size());
		$display("CHECK FAILED");
		$finish;
	end

	// Response side: ready drops in random bursts.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 99) < sink_stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Responses are sampled at the rising edge, before the block updates them.
	always @(posedge clk) begin
		queue_response_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.ok = rsp_ch.ok;
			got.removed_value = rsp_ch.removed_value;
			got.removed_rank = rsp_ch.removed_rank;
			got.occupancy = rsp_ch.occupancy;
			tracker.check_response(got);
		end
	end

	// One request: fields change at the falling edge, valid stays high across
	// back-to-back requests, and the request is noted at the accepting edge.
	task automatic send_request(input logic [1:0] op, input value_t value,
		input logic [ITEM_RANK_W-1:0] rank);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.item_value <= value;
		req_ch.item_rank <= rank;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_request(op, value, rank);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		req_ch.op <= 2'($urandom);
		req_ch.item_value <= value_t'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Sender holds off until the block has answered everything.
	task automatic drain_responses();
		pause_sender(1);
		while (tracker.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Values: a small pool gives duplicates and search hits, stored values
	// make searches hit, the rest spans the full 32 bits.
	function automatic value_t pick_value(input bit searching);
		int roll;
		roll = $urandom_range(0, 99);
		if (searching && tracker.held > 0 && roll < 50)
			return tracker.slot_value[$urandom_range(0, tracker.held - 1)];
		if (roll < 70)
			return value_t'($urandom_range(0, 7));
		if (roll < 75)
			return value_t'(32'h8000_0000 | $urandom_range(0, 1));
		return value_t'($urandom);
	endfunction

	// Ranks: mostly a narrow band so ties are common, now and then extremes.
	function automatic logic [ITEM_RANK_W-1:0] pick_rank();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return ITEM_RANK_W'($urandom_range(0, 3));
		if (roll < 55)
			return (roll < 50) ? '0 : '1;
		return ITEM_RANK_W'($urandom);
	endfunction

	initial begin
		int          phase_items;
		int          roll;
		int          kind;
		int          enq_pct;
		int          deq_pct;
		logic [1:0]  op;

		steady = 1'b0;
		sender_gap_pct = 15;
		sink_stall_pct = 15;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ENQUEUE;
		req_ch.item_value = '0;
		req_ch.item_rank = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty store cases first
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_SEARCH, 32'sd0, 8'd0);
		send_request(OP_UNUSED, -32'sd1, 8'hff);
		// extremes of value and rank, with ties at both rank ends
		send_request(OP_ENQUEUE, value_t'(32'h8000_0000), 8'd0);
		send_request(OP_ENQUEUE, value_t'(32'h7fff_ffff), 8'hff);
		send_request(OP_ENQUEUE, 32'sd0, 8'h80);
		send_request(OP_ENQUEUE, -32'sd1, 8'hff);
		send_request(OP_ENQUEUE, 32'sd5, 8'h80);
		send_request(OP_ENQUEUE, 32'sd7, 8'd0);
		send_request(OP_ENQUEUE, value_t'(32'h5555_aaaa), 8'h55);
		// searches that hit at the low end and next to the head of the store, and a miss
		send_request(OP_SEARCH, value_t'(32'h8000_0000), 8'd0);
		send_request(OP_SEARCH, value_t'(32'h7fff_ffff), 8'h3c);
		send_request(OP_SEARCH, value_t'(32'haaaa_5555), 8'd0);
		send_request(OP_UNUSED, 32'sd0, 8'd0);
		// oldest of the lowest rank leaves first, then the newer tie
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_SEARCH, 32'sd7, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		send_request(OP_DEQUEUE, 32'sd0, 8'd0);
		drain_responses();

		// Random phases: fill-heavy, drain-heavy and balanced mixes in turn, so
		// the store runs into full and empty again and again.
		for (int phase = 0; phase < 20; phase++) begin
			kind = phase % 3;
			phase_items = (phase == 19) ? 200 : 92;
			if (phase == 19)
				steady = 1'b1;
			sender_gap_pct = (phase % 5 == 1) ? 0 : 15;
			sink_stall_pct = (phase % 5 == 2) ? 0 : 15;
			enq_pct = (kind == 0) ? 75 : (kind == 1) ? 15 : 42;
			deq_pct = (kind == 0) ? 10 : (kind == 1) ? 70 : 40;
			for (int n = 0; n < phase_items; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < enq_pct)
					op = OP_ENQUEUE;
				else if (roll < enq_pct + deq_pct)
					op = OP_DEQUEUE;
				else if (roll < 97)
					op = OP_SEARCH;
				else
					op = OP_UNUSED;
				send_request(op, pick_value(op == OP_SEARCH), pick_rank());
				if (!steady && $urandom_range(0, 99) < sender_gap_pct)
					pause_sender($urandom_range(1, 11));
			end
			if (phase % 4 == 3)
				drain_responses();
		end

		// Wind down: nothing more to send, collect what is owed, then keep the clock
		// running so that the block can show any stray response.
		drain_responses();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
